### hdl/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants for the peak/valley average filter.
// ----------------------------------------------------------------------------
package pva_pkg;

  // Sample width, the widths that follow from it, and the fixed threshold and output widths.
  localparam int SAMPLE_BITS    = 32;
  localparam int AVG_BITS       = SAMPLE_BITS + 1;
  localparam int DIFF_BITS      = SAMPLE_BITS + 2;
  localparam int THR_BITS       = 32;
  localparam int CMP_BITS       = ((DIFF_BITS > THR_BITS) ? DIFF_BITS : THR_BITS) + 1;
  localparam int AVG_FRAC_BITS  = 9;
  localparam int AVG_OUT_BITS   = 33;
  localparam int ROUND_OUT_BITS = 25;
  localparam int EXT_BITS       = ((DIFF_BITS > AVG_OUT_BITS + 1) ? DIFF_BITS
                                                                  : AVG_OUT_BITS + 1);

  // Threshold after reset: 40.0 with 9 fractional bits.
  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = THR_BITS'(20480);

  // Rounding bias: half for positive values, just under half for negative ones.
  localparam logic [EXT_BITS-1:0] ROUND_BIAS_POS = EXT_BITS'(1) << (AVG_FRAC_BITS - 1);
  localparam logic [EXT_BITS-1:0] ROUND_BIAS_NEG = ROUND_BIAS_POS - EXT_BITS'(1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [AVG_BITS-1:0]    avg_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_PAIR = 2'd1,
    EV_JUMP = 2'd2
  } event_t;

  // Outcome of one filter step.
  typedef struct packed {
    event_t code;
    avg_t   avg;
  } step_res_t;

endpackage

### hdl/pva_in_if.sv
// ----------------------------------------------------------------------------
// pva_in_if
// Sample channel: valid/ready handshake carrying one signed sample word.
// ----------------------------------------------------------------------------
interface pva_in_if import pva_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### hdl/pva_out_if.sv
// ----------------------------------------------------------------------------
// pva_out_if
// Result channel: valid/ready handshake carrying event code and averages.
// ----------------------------------------------------------------------------
interface pva_out_if import pva_pkg::*; ();
  logic                             valid;
  logic                             ready;
  event_t                           event_code;
  logic signed [AVG_OUT_BITS-1:0]   held_average;
  logic signed [ROUND_OUT_BITS-1:0] rounded_weight;

  modport source (output valid, output event_code, output held_average,
                  output rounded_weight, input ready);
  modport sink   (input valid, input event_code, input held_average,
                  input rounded_weight, output ready);
endinterface

### hdl/pva_core.sv
// ----------------------------------------------------------------------------
// pva_core
// Peak/valley search state and its registered update for each sample word.
// ----------------------------------------------------------------------------
module pva_core import pva_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  sample_t             sample,
  input  logic [THR_BITS-1:0] threshold,
  output step_res_t           res
);

  logic    seek_r, seek_nxt;
  sample_t peak_r, peak_nxt;
  sample_t valley_r, valley_nxt;
  avg_t    avg_r, avg_nxt;

  logic                        test;
  avg_t                        mid;
  logic signed [DIFF_BITS-1:0] diff;
  logic [DIFF_BITS-1:0]        mag;
  event_t                      code;

  // Peak/valley search, then, unless a pair has just ended, the threshold test on the current midpoint.
  always_comb begin
    seek_nxt   = seek_r;
    peak_nxt   = peak_r;
    valley_nxt = valley_r;
    avg_nxt    = avg_r;
    code       = EV_NONE;
    test       = 1'b1;

    if (!seek_r) begin
      if (sample < peak_r) begin
        seek_nxt   = 1'b1;
        valley_nxt = sample;
      end else begin
        peak_nxt = sample;
      end
    end else begin
      if (sample > valley_r) begin
        // The valley has ended: latch the old pair and restart the peak.
        avg_nxt  = {peak_r[SAMPLE_BITS-1], peak_r} + {valley_r[SAMPLE_BITS-1], valley_r};
        seek_nxt = 1'b0;
        peak_nxt = sample;
        code     = EV_PAIR;
        test     = 1'b0;
      end else begin
        valley_nxt = sample;
      end
    end

    mid  = {peak_nxt[SAMPLE_BITS-1], peak_nxt} + {valley_nxt[SAMPLE_BITS-1], valley_nxt};
    diff = {mid[AVG_BITS-1], mid} - {avg_r[AVG_BITS-1], avg_r};
    mag  = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);

    if (test && ({{(CMP_BITS-DIFF_BITS){1'b0}}, mag} >=
                 {{(CMP_BITS-THR_BITS){1'b0}}, threshold})) begin
      avg_nxt = mid;
      code    = EV_JUMP;
    end

    res.code = code;
    res.avg  = avg_nxt;
  end

  // State registers advance only when a sample word is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seek_r   <= 1'b0;
      peak_r   <= '0;
      valley_r <= '0;
      avg_r    <= '0;
    end else if (step) begin
      seek_r   <= seek_nxt;
      peak_r   <= peak_nxt;
      valley_r <= valley_nxt;
      avg_r    <= avg_nxt;
    end
  end

  // A completed pair always returns the search to the peak phase.
  a_pair_restarts_peak: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.code == EV_PAIR |=> !seek_r && peak_r == $past(sample))
    else $error("pair event did not restart the peak search");

  // A step without an event leaves the held average alone.
  a_none_keeps_avg: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.code == EV_NONE |=> $stable(avg_r))
    else $error("held average changed without an event");

  // Without a step no state moves.
  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(seek_r) && $stable(peak_r) && $stable(valley_r) && $stable(avg_r))
    else $error("filter state changed while idle");

endmodule

### hdl/peak_valley_average_filter_unit.sv
// ----------------------------------------------------------------------------
// peak_valley_average_filter_unit
// Peak/valley averaging filter: one signed sample word in, one result word out.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Payload
//   in_chan   input      valid/ready      sample
//   out_chan  output     valid/ready      event_code, held_average, rounded_weight
//   cfg_*     input      cfg_we           cfg_wdata (change threshold)
//
// One word per clock is accepted and one result per clock is delivered while out_chan.ready stays high.
// Each word passes an input register, then the filter step into the
// result register. The peak/valley state updates once per word in pva_core.
// Reset (synchronous, active low) clears the pipeline, the filter state
// and sets the threshold to 40.0. A stalled result holds its register and
// the input stage; in_chan.ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module peak_valley_average_filter_unit import pva_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  pva_in_if.sink              in_chan,
  pva_out_if.source           out_chan,
  input  logic                cfg_we,
  input  logic [THR_BITS-1:0] cfg_wdata
);

  logic                s1_valid_r, s1_valid_nxt;
  sample_t             s1_sample_r, s1_sample_nxt;
  logic                out_valid_r, out_valid_nxt;
  event_t              out_code_r, out_code_nxt;
  avg_t                out_avg_r, out_avg_nxt;
  logic [THR_BITS-1:0] thr_r, thr_nxt;

  logic                       advance;
  logic                       in_acc;
  step_res_t                  res;
  logic signed [EXT_BITS-1:0] avg_ext;
  logic signed [EXT_BITS-1:0] round_sum;
  logic signed [EXT_BITS-1:0] round_shift;

  // Handshake: the step runs when the result register is free or draining.
  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_acc        = in_chan.valid && in_chan.ready;

  pva_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .sample    (s1_sample_r),
    .threshold (thr_r),
    .res       (res)
  );

  // Next values of the input stage, result stage and threshold.
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_sample_nxt = s1_sample_r;
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_avg_nxt   = out_avg_r;
    thr_nxt       = thr_r;

    if (in_acc) begin
      s1_valid_nxt  = 1'b1;
      s1_sample_nxt = in_chan.sample;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    if (advance) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = res.code;
      out_avg_nxt   = res.avg;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      thr_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= THRESHOLD_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      thr_r       <= thr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_sample_r <= s1_sample_nxt;
    out_code_r  <= out_code_nxt;
    out_avg_r   <= out_avg_nxt;
  end

  // Round half away from zero: negative values take a bias one below half.
  always_comb begin
    avg_ext     = {{(EXT_BITS-AVG_BITS){out_avg_r[AVG_BITS-1]}}, out_avg_r};
    round_sum   = avg_ext + (avg_ext[EXT_BITS-1] ? ROUND_BIAS_NEG : ROUND_BIAS_POS);
    round_shift = round_sum >>> AVG_FRAC_BITS;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.event_code     = out_code_r;
  assign out_chan.held_average   = avg_ext[AVG_OUT_BITS-1:0];
  assign out_chan.rounded_weight = round_shift[ROUND_OUT_BITS-1:0];

  // Input stalls only when both pipeline stages hold words.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> s1_valid_r && out_valid_r && !out_chan.ready)
    else $error("input stalled with room in the pipeline");

  // Every accepted word reaches the result register on the following step.
  a_step_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed word did not produce a result");

  // A result waiting for the sink is not overwritten.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(out_avg_r) && $stable(out_code_r))
    else $error("pending result was overwritten");

endmodule

### tb/sv/tb_peak_valley_average_filter_unit.sv
// ----------------------------------------------------------------------------
// tb_peak_valley_average_filter_unit
// Self-checking testbench for the peak/valley average filter. A queue of
// sample words feeds a clocked driver; a clocked monitor predicts the result
// of every accepted word and checks each delivered result against it. The run
// goes through several threshold settings, random idling on both channels
// and long result stalls that back up the input.
// ----------------------------------------------------------------------------
module tb_peak_valley_average_filter_unit;
  import pva_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF    = 6;
  localparam int RESET_LEN   = 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 8;
  localparam int MAX_SHOWN   = 10;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_ITEMS = 230;
  localparam int HOLD_LEN    = 80;

  // Expected content of one result word.
  typedef struct {
    event_t                           code;
    logic signed [AVG_OUT_BITS-1:0]   avg;
    logic signed [ROUND_OUT_BITS-1:0] rnd;
  } filter_result_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [THR_BITS-1:0] cfg_wdata;

  pva_in_if  in_if ();
  pva_out_if out_if ();

  peak_valley_average_filter_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Words waiting to be sent and results waiting to arrive.
  sample_t        sample_queue[$];
  filter_result_t result_queue[$];

  // Predicted filter state and threshold.
  logic                seek_valley_q;
  sample_t             peak_q;
  sample_t             valley_q;
  avg_t                average_q;
  logic [THR_BITS-1:0] threshold_q;

  // Handshake bookkeeping and run statistics.
  int   cycle_count;
  int   error_count;
  int   words_sent;
  int   results_seen;
  int   stall_cycles;
  int   settings_used;
  int   event_count[3];
  int   tx_gap;
  int   rx_gap;
  logic tx_steady;
  logic rx_steady;
  logic rx_hold;
  logic tx_taken;

  // Random sample generator state.
  longint gen_last;
  longint gen_step_max;
  int     gen_dir;

  always #(CLK_HALF) clk = ~clk;

  // One filter step on the predicted state.
  function automatic filter_result_t filter_step(sample_t s);
    filter_result_t r;
    longint         mid;
    longint         diff;
    longint         a;
    longint         rounded;
    logic           run_test;
    r.code   = EV_NONE;
    run_test = 1'b1;
    if (!seek_valley_q) begin
      if (s < peak_q) begin
        seek_valley_q = 1'b1;
        valley_q      = s;
      end else begin
        peak_q = s;
      end
    end else if (s > valley_q) begin
      // The valley has ended: latch the old pair, restart the peak.
      average_q     = avg_t'(longint'(peak_q) + longint'(valley_q));
      seek_valley_q = 1'b0;
      peak_q        = s;
      r.code        = EV_PAIR;
      run_test      = 1'b0;
    end else begin
      valley_q = s;
    end
    if (run_test) begin
      mid  = longint'(peak_q) + longint'(valley_q);
      diff = mid - longint'(average_q);
      if (diff < 0) diff = -diff;
      if (diff >= longint'({32'd0, threshold_q})) begin
        average_q = avg_t'(mid);
        r.code    = EV_JUMP;
      end
    end
    // Round half away from zero on the magnitude.
    a       = longint'(average_q);
    rounded = ((a < 0) ? -a : a) + (longint'(1) << (AVG_FRAC_BITS - 1));
    rounded = rounded >>> AVG_FRAC_BITS;
    if (a < 0) rounded = -rounded;
    r.avg = average_q;
    r.rnd = rounded[ROUND_OUT_BITS-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Random words: mostly ramps up and down around a level, so that peaks,
  // valleys and threshold jumps all happen; some repeats and raw noise.
  task automatic queue_random(int count);
    int     kind;
    longint next;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        next = longint'(int'($urandom));
      end else if (kind < 3) begin
        next = gen_last;
      end else if (kind == 3) begin
        if ($urandom_range(0, 3) == 0) next = longint'(int'($urandom));
        else next = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
        case ($urandom_range(0, 3))
          0: gen_step_max = 16;
          1: gen_step_max = 2000;
          2: gen_step_max = 20000;
          default: gen_step_max = 1 << 20;
        endcase
      end else begin
        if ($urandom_range(0, 3) == 0) gen_dir = -gen_dir;
        next = gen_last + gen_dir * longint'($urandom_range(0, int'(gen_step_max)));
      end
      gen_last = clamp32(next);
      sample_queue.push_back(sample_t'(gen_last));
    end
  endtask

  // Waits until every word has gone through and the pipeline has emptied.
  task automatic wait_idle();
    while (sample_queue.size() != 0 || result_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    threshold_q = value;
    settings_used++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender: offers the head of the queue and holds it until it is taken.
  // Whether the word was taken comes from the handshake at the rising edge.
  always @(negedge clk) begin
    logic    next_valid;
    sample_t next_sample;
    next_valid  = in_if.valid;
    next_sample = in_if.sample;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!in_if.valid || tx_taken) begin
      if (in_if.valid) tx_gap = (tx_steady || rx_hold) ? 0 : pick_gap();
      if (tx_gap > 0 && !rx_hold) begin
        tx_gap--;
        next_valid = 1'b0;
      end else if (sample_queue.size() != 0) begin
        next_valid  = 1'b1;
        next_sample = sample_queue[0];
      end else begin
        next_valid = 1'b0;
      end
    end
    in_if.valid  <= next_valid;
    in_if.sample <= next_sample;
  end

  // Receiver: random stalls, or a long hold while the pressure test runs.
  always @(negedge clk) begin
    logic next_ready;
    if (!rst_n || rx_hold) begin
      next_ready = 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
      if (!rx_steady) rx_gap = pick_gap();
    end
    out_if.ready <= next_ready;
  end

  // Input side: every accepted word gets its expected result.
  always @(posedge clk) begin
    tx_taken = rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      result_queue.push_back(filter_step(in_if.sample));
      void'(sample_queue.pop_front());
      words_sent++;
    end
    if (rst_n && in_if.valid && !in_if.ready) stall_cycles++;
  end

  // Output side: compare each delivered result with the oldest expectation.
  always @(posedge clk) begin
    filter_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (result_queue.size() == 0) begin
        error_count++;
        if (error_count <= MAX_SHOWN)
          $display("unexpected result word: code %0d avg %0d rnd %0d",
                   out_if.event_code, out_if.held_average, out_if.rounded_weight);
      end else begin
        want = result_queue.pop_front();
        if (out_if.event_code <= EV_JUMP) event_count[out_if.event_code]++;
        if (out_if.event_code !== want.code || out_if.held_average !== want.avg ||
            out_if.rounded_weight !== want.rnd) begin
          error_count++;
          if (error_count <= MAX_SHOWN)
            $display("mismatch at result %0d: code %0d/%0d avg %0d/%0d rnd %0d/%0d",
                     results_seen, want.code, out_if.event_code, want.avg,
                     out_if.held_average, want.rnd, out_if.rounded_weight);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, result_queue.size());
      $display("[peak_valley_average_filter_unit] ERROR");
      $finish;
    end
  end

  // Back-pressure: the receiver stops for a long stretch twice while the
  // sender keeps offering words, so that both pipeline stages fill up.
  initial begin
    rx_hold = 1'b0;
    wait (words_sent >= 400);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    rx_hold = 1'b0;
    wait (words_sent >= 1200);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Reset, directed words, then random phases under several thresholds.
  initial begin
    logic [THR_BITS-1:0] phase_thr;
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.sample  = '0;
    out_if.ready  = 1'b0;
    seek_valley_q = 1'b0;
    peak_q        = '0;
    valley_q      = '0;
    average_q     = '0;
    threshold_q   = THRESHOLD_RESET;
    cycle_count   = 0;
    error_count   = 0;
    words_sent    = 0;
    results_seen  = 0;
    stall_cycles  = 0;
    settings_used = 1;
    event_count   = '{0, 0, 0};
    tx_gap        = 0;
    rx_gap        = 0;
    tx_steady     = 1'b1;
    rx_steady     = 1'b1;
    tx_taken      = 1'b0;
    gen_last      = 0;
    gen_step_max  = 2000;
    gen_dir       = 1;

    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset threshold: extremes, repeated peak and
    // valley values, valley ends and small moves under the threshold.
    sample_queue.push_back(32'sh7FFF_FFFF);
    sample_queue.push_back(32'sh7FFF_FFFF);
    sample_queue.push_back(32'sh8000_0000);
    sample_queue.push_back(32'sh8000_0000);
    sample_queue.push_back(32'sh0000_0000);
    sample_queue.push_back(-32'sd1);
    sample_queue.push_back(-32'sd1);
    sample_queue.push_back(32'sd5);
    sample_queue.push_back(32'sd100);
    sample_queue.push_back(32'sd100);
    sample_queue.push_back(32'sd20000);
    sample_queue.push_back(32'sd9000);
    sample_queue.push_back(32'sd9000);
    sample_queue.push_back(32'sd8999);
    sample_queue.push_back(32'sd9001);
    sample_queue.push_back(32'sh5555_5555);
    sample_queue.push_back(32'shAAAA_AAAA);
    sample_queue.push_back(32'sh7FFF_FFFF);
    sample_queue.push_back(-32'sd255);
    sample_queue.push_back(-32'sd256);
    sample_queue.push_back(-32'sd257);
    sample_queue.push_back(32'sh8000_0000);
    sample_queue.push_back(32'sh8000_0001);
    wait_idle();

    // Random phases, threshold extremes among them, varied idling patterns.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_thr = '0;
        1: phase_thr = '1;
        2: phase_thr = $urandom_range(1, 65535);
        3: phase_thr = $urandom;
        4: phase_thr = THRESHOLD_RESET;
        5: phase_thr = 32'd1;
        default: phase_thr = $urandom_range(256, 40000);
      endcase
      write_threshold(phase_thr);
      tx_steady = (p % 3 == 1);
      rx_steady = (p % 3 == 2);
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    $display("covered %0d words under %0d threshold settings; events none/pair/jump %0d/%0d/%0d",
             words_sent, settings_used, event_count[0], event_count[1], event_count[2]);
    $display("input was held off by back-pressure for %0d cycles", stall_cycles);
    if (error_count == 0 && result_queue.size() == 0) begin
      $display("[peak_valley_average_filter_unit] OK");
    end else begin
      $display("%0d failures, %0d results missing", error_count, result_queue.size());
      $display("[peak_valley_average_filter_unit] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/pva_pkg.sv
hdl/pva_in_if.sv
hdl/pva_out_if.sv
hdl/pva_core.sv
hdl/peak_valley_average_filter_unit.sv
tb/sv/tb_peak_valley_average_filter_unit.sv
